/* rtl/htw_pkg.sv */
// htw_pkg: shared types and codes for the hierarchical timer wheel
// transaction structs, datapath operation codes, controller states
// no dependencies; used by htw_ctrl, htw_datapath and hierarchical_timer_wheel
package htw_pkg;

  localparam int TIME_W = 32;
  localparam int ID_W   = 16;

  typedef enum logic [1:0] {
    MODE_CREATE   = 2'd0,
    MODE_KILL     = 2'd1,
    MODE_TICK     = 2'd2,
    MODE_KILL_ALL = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_CREATED     = 3'd0,
    KIND_CREATE_REJ  = 3'd1,
    KIND_KILLED      = 3'd2,
    KIND_KILL_REJ    = 3'd3,
    KIND_ALL_KILLED  = 3'd4,
    KIND_EXPIRED     = 3'd5
  } kind_t;

  typedef struct packed {
    mode_t              mode;
    logic [ID_W-1:0]    timer_id;
    logic [TIME_W-1:0]  due_time;
    logic [TIME_W-1:0]  period;
  } req_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    timer_id_res;
    logic               last;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_SCAN,
    OP_KILL,
    OP_CREATE,
    OP_KILL_ALL,
    OP_FILE0,
    OP_FILE1,
    OP_TICK_START,
    OP_CASC_DETACH,
    OP_CASC_NEXT,
    OP_EXP_DETACH,
    OP_WALK_LOAD,
    OP_REFILE_CASC,
    OP_REFILE_EXP,
    OP_DROP,
    OP_WALK_ADV,
    OP_TIME_INC
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    emit;
    kind_t   kind;
    logic    flush;
  } cmd_t;

  typedef struct packed {
    logic   clear_done;
    logic   bad_args;
    mode_t  mode;
    logic   scan_done;
    logic   dup_found;
    logic   free_found;
    logic   file_out;
    logic   casc_start;
    logic   casc_more;
    logic   cur_none;
    logic   cur_running;
    logic   per_zero;
    logic   pend_v;
    logic   out_free;
  } stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SCAN_END,
    ST_FILE0,
    ST_FILE1,
    ST_TICK,
    ST_CASC_DETACH,
    ST_EXP_DETACH,
    ST_WALK_LOAD,
    ST_WALK_CHK,
    ST_WALK_PROC,
    ST_WALK_ADV,
    ST_FLUSH
  } state_t;

endpackage

/* rtl/htw_datapath.sv */
// htw_datapath: slot and node memories, time counter, pool flags, result staging
// executes one htw_pkg::dp_op_t per cycle as commanded by htw_ctrl
// depends on htw_pkg
module htw_datapath #(
  parameter int WHEEL_BITS = 8,
  parameter int WHEELS     = 4,
  parameter int MAX_TIMERS = 64,
  parameter int ID_BITS    = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  htw_pkg::cmd_t  cmd,
  output htw_pkg::stat_t stat,
  input  htw_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output htw_pkg::rsp_t  rsp
);

  localparam int SLOTS  = 1 << WHEEL_BITS;
  localparam int SDEPTH = WHEELS * SLOTS;
  localparam int SA     = $clog2(SDEPTH);
  localparam int NB     = $clog2(MAX_TIMERS);
  localparam int LB     = $clog2(MAX_TIMERS + 1);
  localparam int WW     = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam int HBITS  = WHEEL_BITS * WHEELS;
  localparam int IDW    = (ID_BITS < 16) ? ID_BITS : 16;
  localparam logic [LB-1:0] NONE = LB'(MAX_TIMERS);

  // slot lists and node pool
  logic [LB-1:0]  head_mem [SDEPTH];
  logic [LB-1:0]  tail_mem [SDEPTH];
  logic [LB-1:0]  next_mem [MAX_TIMERS];
  logic [31:0]    exp_mem  [MAX_TIMERS];
  logic [31:0]    per_mem  [MAX_TIMERS];
  logic [IDW-1:0] id_mem   [MAX_TIMERS];

  logic [31:0]           now;
  htw_pkg::mode_t        item_mode;
  logic [IDW-1:0]        item_id;
  logic [31:0]           item_due;
  logic [31:0]           item_per;
  logic [NB-1:0]         scan;
  logic [NB-1:0]         scan_d;
  logic                  scan_dv;
  logic                  dup_found;
  logic [NB-1:0]         dup_idx;
  logic                  free_found;
  logic [NB-1:0]         free_idx;
  logic [MAX_TIMERS-1:0] in_use;
  logic [MAX_TIMERS-1:0] running;
  logic [LB-1:0]         cur;
  logic [LB-1:0]         nxt_r;
  logic [31:0]           exp_r;
  logic [SA-1:0]         slot_r;
  logic [LB-1:0]         tail_q;
  logic [LB-1:0]         head_q;
  logic [LB-1:0]         nx_q;
  logic [31:0]           exp_q;
  logic [31:0]           per_q;
  logic [IDW-1:0]        id_q;
  logic [WW-1:0]         cw;
  logic                  d_zero;
  logic [SA-1:0]         clr;
  logic                  pend_v;
  htw_pkg::kind_t        pend_kind;
  logic [15:0]           pend_id;
  logic                  out_v;
  htw_pkg::rsp_t         out_q;

  logic [NB-1:0]         ci;
  logic [NB-1:0]         nrd;
  logic [31:0]           delta;
  logic [WW-1:0]         fw;
  logic [WHEEL_BITS-1:0] fdig;
  logic [SA-1:0]         fslot;
  logic                  file_out;
  logic [WHEEL_BITS-1:0] cdig;
  logic [SA-1:0]         det_slot;
  logic                  s_hit;
  logic                  s_free;
  logic                  out_free;
  logic [15:0]           emit_id;

  assign ci  = cur[NB-1:0];
  assign nrd = (cmd.op == htw_pkg::OP_SCAN) ? scan : ci;

  // target slot of the node being filed
  always_comb begin
    delta = exp_r - now;
    fw    = WW'(WHEELS - 1);
    for (int k = WHEELS - 2; k >= 0; k--) begin
      if ((delta >> (WHEEL_BITS * (k + 1))) == 32'd0) fw = WW'(k);
    end
    fdig     = WHEEL_BITS'(exp_r >> (WHEEL_BITS * int'(fw)));
    fslot    = SA'(SA'(fw) << WHEEL_BITS) | SA'(fdig);
    file_out = (delta >> HBITS) != 32'd0;
  end

  // slot to detach: cascade wheel digit or wheel 0 digit
  always_comb begin
    cdig = WHEEL_BITS'(now >> (WHEEL_BITS * int'(cw)));
    if (cmd.op == htw_pkg::OP_EXP_DETACH) begin
      det_slot = SA'(now[WHEEL_BITS-1:0]);
    end else begin
      det_slot = SA'(SA'(cw) << WHEEL_BITS) | SA'(cdig);
    end
  end

  // pool scan compare stage
  assign s_hit  = scan_dv && in_use[scan_d] && running[scan_d] && (id_q == item_id);
  assign s_free = scan_dv && !in_use[scan_d];

  assign out_free = !out_v || !rsp_stall;

  always_comb begin
    case (cmd.kind)
      htw_pkg::KIND_EXPIRED:    emit_id = 16'(id_q);
      htw_pkg::KIND_ALL_KILLED: emit_id = 16'd0;
      default:                  emit_id = 16'(item_id);
    endcase
  end

  // slot memories
  always_ff @(posedge clk) begin
    unique case (cmd.op) inside
      htw_pkg::OP_CLEAR: begin
        head_mem[clr] <= NONE;
        tail_mem[clr] <= NONE;
      end
      htw_pkg::OP_CASC_DETACH, htw_pkg::OP_EXP_DETACH: begin
        head_mem[det_slot] <= NONE;
        tail_mem[det_slot] <= NONE;
        head_q             <= head_mem[det_slot];
      end
      htw_pkg::OP_FILE0: begin
        tail_q <= tail_mem[fslot];
      end
      htw_pkg::OP_FILE1: begin
        if (tail_q == NONE) head_mem[slot_r] <= cur;
        tail_mem[slot_r] <= cur;
      end
      default: begin
      end
    endcase
  end

  // node memories
  always_ff @(posedge clk) begin
    nx_q  <= next_mem[nrd];
    exp_q <= exp_mem[nrd];
    per_q <= per_mem[nrd];
    id_q  <= id_mem[nrd];
    unique case (cmd.op)
      htw_pkg::OP_CREATE: begin
        exp_mem[free_idx] <= now + item_due;
        per_mem[free_idx] <= item_per;
        id_mem[free_idx]  <= item_id;
      end
      htw_pkg::OP_REFILE_EXP: begin
        exp_mem[ci] <= now + per_q;
      end
      htw_pkg::OP_FILE0: begin
        if (!file_out) next_mem[ci] <= NONE;
      end
      htw_pkg::OP_FILE1: begin
        if (tail_q != NONE) next_mem[tail_q[NB-1:0]] <= cur;
      end
      default: begin
      end
    endcase
  end

  // item, filing and walk payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op) inside
      htw_pkg::OP_ACCEPT: begin
        item_mode <= req.mode;
        item_id   <= IDW'(req.timer_id);
        item_due  <= req.due_time;
        item_per  <= req.period;
      end
      htw_pkg::OP_CREATE: begin
        exp_r <= now + item_due;
      end
      htw_pkg::OP_FILE0: begin
        slot_r <= fslot;
      end
      htw_pkg::OP_CASC_DETACH: begin
        d_zero <= (cdig == '0);
      end
      htw_pkg::OP_REFILE_CASC: begin
        exp_r <= exp_q;
        nxt_r <= nx_q;
      end
      htw_pkg::OP_REFILE_EXP: begin
        exp_r <= now + per_q;
        nxt_r <= nx_q;
      end
      htw_pkg::OP_DROP: begin
        nxt_r <= nx_q;
      end
      default: begin
      end
    endcase
    if (scan_dv && s_hit && !dup_found) dup_idx <= scan_d;
    if (scan_dv && s_free && !free_found) free_idx <= scan_d;
    if (cmd.op == htw_pkg::OP_SCAN) scan_d <= scan;
    if (cmd.emit) begin
      pend_kind <= cmd.kind;
      pend_id   <= emit_id;
    end
    if (cmd.emit && pend_v) begin
      out_q <= '{kind: pend_kind, timer_id_res: pend_id, last: 1'b0};
    end else if (cmd.flush) begin
      out_q <= '{kind: pend_kind, timer_id_res: pend_id, last: 1'b1};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      now        <= '0;
      scan       <= '0;
      scan_dv    <= 1'b0;
      dup_found  <= 1'b0;
      free_found <= 1'b0;
      in_use     <= '0;
      running    <= '0;
      cur        <= NONE;
      cw         <= '0;
      clr        <= '0;
      pend_v     <= 1'b0;
      out_v      <= 1'b0;
    end else begin
      scan_dv <= (cmd.op == htw_pkg::OP_SCAN);
      if (s_hit) dup_found <= 1'b1;
      if (s_free) free_found <= 1'b1;
      unique case (cmd.op)
        htw_pkg::OP_CLEAR:      clr <= clr + SA'(1);
        htw_pkg::OP_ACCEPT: begin
          scan       <= '0;
          dup_found  <= 1'b0;
          free_found <= 1'b0;
        end
        htw_pkg::OP_SCAN:       scan <= scan + NB'(1);
        htw_pkg::OP_KILL:       running[dup_idx] <= 1'b0;
        htw_pkg::OP_CREATE: begin
          in_use[free_idx]  <= 1'b1;
          running[free_idx] <= 1'b1;
          cur               <= LB'(free_idx);
        end
        htw_pkg::OP_KILL_ALL:   running <= '0;
        htw_pkg::OP_FILE0: begin
          if (file_out) begin
            in_use[ci]  <= 1'b0;
            running[ci] <= 1'b0;
          end
        end
        htw_pkg::OP_TICK_START: cw <= WW'(1);
        htw_pkg::OP_CASC_NEXT:  cw <= cw + WW'(1);
        htw_pkg::OP_WALK_LOAD:  cur <= head_q;
        htw_pkg::OP_DROP: begin
          in_use[ci]  <= 1'b0;
          running[ci] <= 1'b0;
        end
        htw_pkg::OP_WALK_ADV:   cur <= nxt_r;
        htw_pkg::OP_TIME_INC:   now <= now + 32'd1;
        default: begin
        end
      endcase
      // result staging: pending result, then output register
      if (cmd.emit) begin
        pend_v <= 1'b1;
        if (pend_v) out_v <= 1'b1;
        else if (out_v && !rsp_stall) out_v <= 1'b0;
      end else if (cmd.flush) begin
        pend_v <= 1'b0;
        out_v  <= 1'b1;
      end else if (out_v && !rsp_stall) begin
        out_v <= 1'b0;
      end
    end
  end

  assign rsp_valid = out_v;
  assign rsp       = out_q;

  // status to the controller
  assign stat.clear_done  = (clr == SA'(SDEPTH - 1));
  assign stat.bad_args    = (item_due == 32'd0) || ((item_due >> HBITS) != 32'd0)
                            || ((item_per >> HBITS) != 32'd0);
  assign stat.mode        = item_mode;
  assign stat.scan_done   = scan_dv && (scan_d == NB'(MAX_TIMERS - 1));
  assign stat.dup_found   = dup_found;
  assign stat.free_found  = free_found;
  assign stat.file_out    = file_out;
  assign stat.casc_start  = (WHEELS > 1) && (now[WHEEL_BITS-1:0] == '0);
  assign stat.casc_more   = (int'(cw) < WHEELS - 1) && d_zero;
  assign stat.cur_none    = (cur == NONE);
  assign stat.cur_running = running[ci];
  assign stat.per_zero    = (per_q == 32'd0);
  assign stat.pend_v      = pend_v;
  assign stat.out_free    = out_free;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_v && rsp_stall && pend_v) |-> !(cmd.emit || cmd.flush))
    else $error("output register overwritten while stalled");

  a_cur_range: assert property (@(posedge clk) disable iff (rst) cur <= NONE)
    else $error("current node pointer out of range");

  a_run_in_use: assert property (@(posedge clk) disable iff (rst)
    (running & ~in_use) == '0)
    else $error("running node not in use");
`endif

endmodule

/* rtl/htw_ctrl.sv */
// htw_ctrl: sequencing state machine for the hierarchical timer wheel
// issues one datapath operation per cycle and steers scans, list walks and filing
// depends on htw_pkg
module htw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  htw_pkg::stat_t stat,
  output htw_pkg::cmd_t  cmd
);

  htw_pkg::state_t state;
  htw_pkg::state_t state_next;
  logic            phase;
  logic            phase_next;
  logic            emit_ok;
  logic            is_create;

  assign emit_ok   = !stat.pend_v || stat.out_free;
  assign is_create = (stat.mode == htw_pkg::MODE_CREATE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htw_pkg::ST_CLEAR;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '{op: htw_pkg::OP_NONE, emit: 1'b0, kind: htw_pkg::KIND_CREATED,
                   flush: 1'b0};
    req_stall  = 1'b1;
    unique case (state)
      htw_pkg::ST_CLEAR: begin
        cmd.op = htw_pkg::OP_CLEAR;
        if (stat.clear_done) state_next = htw_pkg::ST_IDLE;
      end
      htw_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.op     = htw_pkg::OP_ACCEPT;
          state_next = htw_pkg::ST_DECODE;
        end
      end
      htw_pkg::ST_DECODE: begin
        unique case (stat.mode)
          htw_pkg::MODE_CREATE: begin
            if (stat.bad_args) begin
              cmd.emit   = 1'b1;
              cmd.kind   = htw_pkg::KIND_CREATE_REJ;
              state_next = htw_pkg::ST_FLUSH;
            end else begin
              state_next = htw_pkg::ST_SCAN;
            end
          end
          htw_pkg::MODE_KILL: state_next = htw_pkg::ST_SCAN;
          htw_pkg::MODE_TICK: state_next = htw_pkg::ST_TICK;
          default: begin
            cmd.op     = htw_pkg::OP_KILL_ALL;
            cmd.emit   = 1'b1;
            cmd.kind   = htw_pkg::KIND_ALL_KILLED;
            state_next = htw_pkg::ST_FLUSH;
          end
        endcase
      end
      htw_pkg::ST_SCAN: begin
        if (stat.scan_done) state_next = htw_pkg::ST_SCAN_END;
        else cmd.op = htw_pkg::OP_SCAN;
      end
      htw_pkg::ST_SCAN_END: begin
        cmd.emit   = 1'b1;
        state_next = htw_pkg::ST_FLUSH;
        if (!is_create) begin
          if (stat.dup_found) begin
            cmd.op   = htw_pkg::OP_KILL;
            cmd.kind = htw_pkg::KIND_KILLED;
          end else begin
            cmd.kind = htw_pkg::KIND_KILL_REJ;
          end
        end else if (stat.dup_found || !stat.free_found) begin
          cmd.kind = htw_pkg::KIND_CREATE_REJ;
        end else begin
          cmd.op     = htw_pkg::OP_CREATE;
          cmd.kind   = htw_pkg::KIND_CREATED;
          state_next = htw_pkg::ST_FILE0;
        end
      end
      htw_pkg::ST_FILE0: begin
        cmd.op = htw_pkg::OP_FILE0;
        if (!stat.file_out) state_next = htw_pkg::ST_FILE1;
        else if (is_create) state_next = htw_pkg::ST_FLUSH;
        else state_next = htw_pkg::ST_WALK_ADV;
      end
      htw_pkg::ST_FILE1: begin
        cmd.op     = htw_pkg::OP_FILE1;
        state_next = is_create ? htw_pkg::ST_FLUSH : htw_pkg::ST_WALK_ADV;
      end
      htw_pkg::ST_TICK: begin
        if (stat.casc_start) begin
          cmd.op     = htw_pkg::OP_TICK_START;
          state_next = htw_pkg::ST_CASC_DETACH;
        end else begin
          state_next = htw_pkg::ST_EXP_DETACH;
        end
      end
      htw_pkg::ST_CASC_DETACH: begin
        cmd.op     = htw_pkg::OP_CASC_DETACH;
        phase_next = 1'b0;
        state_next = htw_pkg::ST_WALK_LOAD;
      end
      htw_pkg::ST_EXP_DETACH: begin
        cmd.op     = htw_pkg::OP_EXP_DETACH;
        phase_next = 1'b1;
        state_next = htw_pkg::ST_WALK_LOAD;
      end
      htw_pkg::ST_WALK_LOAD: begin
        cmd.op     = htw_pkg::OP_WALK_LOAD;
        state_next = htw_pkg::ST_WALK_CHK;
      end
      htw_pkg::ST_WALK_CHK: begin
        if (!stat.cur_none) begin
          state_next = htw_pkg::ST_WALK_PROC;
        end else if (phase) begin
          cmd.op     = htw_pkg::OP_TIME_INC;
          state_next = htw_pkg::ST_FLUSH;
        end else if (stat.casc_more) begin
          cmd.op     = htw_pkg::OP_CASC_NEXT;
          state_next = htw_pkg::ST_CASC_DETACH;
        end else begin
          state_next = htw_pkg::ST_EXP_DETACH;
        end
      end
      htw_pkg::ST_WALK_PROC: begin
        if (!stat.cur_running) begin
          cmd.op     = htw_pkg::OP_DROP;
          state_next = htw_pkg::ST_WALK_ADV;
        end else if (!phase) begin
          cmd.op     = htw_pkg::OP_REFILE_CASC;
          state_next = htw_pkg::ST_FILE0;
        end else if (emit_ok) begin
          cmd.emit = 1'b1;
          cmd.kind = htw_pkg::KIND_EXPIRED;
          if (stat.per_zero) begin
            cmd.op     = htw_pkg::OP_DROP;
            state_next = htw_pkg::ST_WALK_ADV;
          end else begin
            cmd.op     = htw_pkg::OP_REFILE_EXP;
            state_next = htw_pkg::ST_FILE0;
          end
        end
      end
      htw_pkg::ST_WALK_ADV: begin
        cmd.op     = htw_pkg::OP_WALK_ADV;
        state_next = htw_pkg::ST_WALK_CHK;
      end
      htw_pkg::ST_FLUSH: begin
        if (!stat.pend_v) begin
          state_next = htw_pkg::ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = htw_pkg::ST_IDLE;
        end
      end
      default: state_next = htw_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |-> !stat.pend_v)
    else $error("transaction accepted with a result still pending");
`endif

endmodule

/* rtl/hierarchical_timer_wheel.sv */
// kill and a create with valid arguments scan the pool at one node per cycle;
//   a waiting result stalls the sequence
// tick: walks the list of each cascaded wheel's slot and of wheel 0's slot, dropping or refiling
//   each node; the walk is sequenced over the single-port node and slot memories
// one transaction in work at a time; the next is taken the cycle after the previous one ends
// reset: synchronous; a clearing pass over all WHEELS*2^WHEEL_BITS slots empties the slot lists
module hierarchical_timer_wheel #(
  parameter int WHEEL_BITS = 8,
  parameter int WHEELS     = 4,
  parameter int MAX_TIMERS = 64,
  parameter int ID_BITS    = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  htw_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output htw_pkg::rsp_t rsp
);

  htw_pkg::cmd_t  cmd;
  htw_pkg::stat_t stat;

  // sequencing
  htw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and arithmetic
  htw_datapath #(
    .WHEEL_BITS (WHEEL_BITS),
    .WHEELS     (WHEELS),
    .MAX_TIMERS (MAX_TIMERS),
    .ID_BITS    (ID_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

/* tb/sv/tb_hierarchical_timer_wheel.sv */
`timescale 1ns / 100ps
// tb_hierarchical_timer_wheel: self-checking testbench for the hierarchical timer wheel
// depends on htw_pkg (transaction structs, mode and kind codes) and hierarchical_timer_wheel
module tb_hierarchical_timer_wheel;

  localparam int WB    = 8;
  localparam int NW    = 4;
  localparam int NT    = 64;
  localparam int NSL   = 1 << WB;
  localparam int HB    = WB * NW;
  localparam logic [6:0] NO_NODE = 7'(NT);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  htw_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  htw_pkg::rsp_t rsp;

  hierarchical_timer_wheel #(
    .WHEEL_BITS(WB), .WHEELS(NW), .MAX_TIMERS(NT), .ID_BITS(16)
  ) u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // shadow copy of the wheel state
  logic [31:0] now_ticks;
  logic [6:0]  slot_first [NW*NSL];
  logic [6:0]  slot_last  [NW*NSL];
  logic [6:0]  node_next  [NT];
  logic [31:0] node_due   [NT];
  logic [31:0] node_rep   [NT];
  logic [15:0] node_id    [NT];
  bit          node_busy  [NT];
  bit          node_live  [NT];

  htw_pkg::rsp_t expected_rsp [$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int items_sent = 0;
  int rsp_seen = 0;
  int expiries_seen = 0;

  function automatic bit fits(input logic [31:0] v, input int bits);
    if (bits >= 32) return 1'b1;
    return (v >> bits) == 0;
  endfunction

  function automatic logic [31:0] slot_digit(input logic [31:0] t, input int w);
    if (WB * w >= 32) return '0;
    return (t >> (WB * w)) & (NSL - 1);
  endfunction

  function automatic void file_timer(input int n);
    logic [31:0] delta;
    int w;
    int s;
    delta = node_due[n] - now_ticks;
    if (!fits(delta, HB)) begin
      node_busy[n] = 1'b0;
      node_live[n] = 1'b0;
      return;
    end
    for (w = 0; w + 1 < NW; w++)
      if (fits(delta, WB * (w + 1))) break;
    s = w * NSL + int'(slot_digit(node_due[n], w));
    node_next[n] = NO_NODE;
    if (slot_last[s] == NO_NODE) slot_first[s] = 7'(n);
    else node_next[slot_last[s]] = 7'(n);
    slot_last[s] = 7'(n);
  endfunction

  function automatic logic [6:0] take_slot(input int s);
    logic [6:0] h;
    h = slot_first[s];
    slot_first[s] = NO_NODE;
    slot_last[s] = NO_NODE;
    return h;
  endfunction

  function automatic void expect_rsp(input htw_pkg::kind_t k, input logic [15:0] id);
    htw_pkg::rsp_t r;
    r.kind = k;
    r.timer_id_res = id;
    r.last = 1'b0;
    expected_rsp.push_back(r);
  endfunction

  // expected results of one accepted transaction
  function automatic void predict_wheel(input htw_pkg::req_t item);
    int cnt;
    int fr;
    int i;
    int guard;
    bit bad;
    bit hit;
    logic [31:0] exec;
    logic [31:0] nxt;
    logic [6:0] n;
    logic [6:0] nx;
    htw_pkg::rsp_t r;
    cnt = 0;
    case (item.mode)
      htw_pkg::MODE_CREATE: begin
        fr = NT;
        bad = (item.due_time == 0) || !fits(item.due_time, HB) || !fits(item.period, HB);
        for (i = 0; i < NT && !bad; i++)
          if (node_busy[i] && node_live[i] && node_id[i] == item.timer_id) bad = 1'b1;
        for (i = 0; i < NT && !bad; i++)
          if (!node_busy[i]) begin
            fr = i;
            break;
          end
        if (!bad && fr < NT) begin
          node_busy[fr] = 1'b1;
          node_live[fr] = 1'b1;
          node_id[fr] = item.timer_id;
          node_rep[fr] = item.period;
          node_due[fr] = now_ticks + item.due_time;
          file_timer(fr);
          expect_rsp(htw_pkg::KIND_CREATED, item.timer_id);
        end else begin
          expect_rsp(htw_pkg::KIND_CREATE_REJ, item.timer_id);
        end
        cnt = 1;
      end
      htw_pkg::MODE_KILL: begin
        hit = 1'b0;
        for (i = 0; i < NT; i++)
          if (node_busy[i] && node_live[i] && node_id[i] == item.timer_id) begin
            node_live[i] = 1'b0;
            hit = 1'b1;
            break;
          end
        if (hit) expect_rsp(htw_pkg::KIND_KILLED, item.timer_id);
        else expect_rsp(htw_pkg::KIND_KILL_REJ, item.timer_id);
        cnt = 1;
      end
      htw_pkg::MODE_KILL_ALL: begin
        for (i = 0; i < NT; i++) node_live[i] = 1'b0;
        expect_rsp(htw_pkg::KIND_ALL_KILLED, '0);
        cnt = 1;
      end
      default: begin
        exec = now_ticks & (NSL - 1);
        nxt = exec;
        // cascade higher wheels while the digit below is zero
        for (i = 0; i + 1 < NW && nxt == 0; i++) begin
          nxt = slot_digit(now_ticks, i + 1);
          n = take_slot((i + 1) * NSL + int'(nxt & (NSL - 1)));
          guard = 0;
          while (n < NO_NODE && guard++ < NT) begin
            nx = node_next[n];
            if (node_live[n]) file_timer(n);
            else node_busy[n] = 1'b0;
            n = nx;
          end
        end
        // expiry walk of wheel 0
        n = take_slot(int'(exec));
        guard = 0;
        while (n < NO_NODE && guard++ < NT) begin
          nx = node_next[n];
          if (node_live[n]) begin
            if (cnt < NT) begin
              expect_rsp(htw_pkg::KIND_EXPIRED, node_id[n]);
              cnt++;
            end
            if (node_rep[n] != 0) begin
              node_due[n] = now_ticks + node_rep[n];
              file_timer(n);
            end else begin
              node_busy[n] = 1'b0;
              node_live[n] = 1'b0;
            end
          end else begin
            node_busy[n] = 1'b0;
          end
          n = nx;
        end
        now_ticks = now_ticks + 1;
      end
    endcase
    if (cnt > 0) begin
      r = expected_rsp.pop_back();
      r.last = 1'b1;
      expected_rsp.push_back(r);
    end
  endfunction

  function automatic htw_pkg::req_t make_req(input htw_pkg::mode_t m, input logic [15:0] id,
                                             input logic [31:0] due, input logic [31:0] per);
    htw_pkg::req_t r;
    r.mode = m;
    r.timer_id = id;
    r.due_time = due;
    r.period = per;
    return r;
  endfunction

  // one request transaction, with a random gap in front
  task automatic send_item(input htw_pkg::req_t item);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    predict_wheel(item);
    items_sent++;
  endtask

  task automatic send_ticks(input int cnt);
    repeat (cnt) send_item(make_req(htw_pkg::MODE_TICK, 16'($urandom), $urandom, $urandom));
  endtask

  // receiver back-pressure
  always @(negedge clk)
    rsp_stall <= ($urandom_range(99) < stall_pct);

  // result checker
  always @(posedge clk) begin
    htw_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_seen++;
      if (rsp.kind == htw_pkg::KIND_EXPIRED) expiries_seen++;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d id %h last %b", rsp.kind, rsp.timer_id_res,
                   rsp.last);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.kind !== want.kind || rsp.timer_id_res !== want.timer_id_res ||
            rsp.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d id %h last %b, got kind %0d id %h last %b",
                     want.kind, want.timer_id_res, want.last,
                     rsp.kind, rsp.timer_id_res, rsp.last);
        end
      end
    end
  end

  // every operation, field extremes, duplicates, zero due, unknown kill, quiet tick
  task automatic test_basic_ops;
    send_item(make_req(htw_pkg::MODE_TICK, 16'h0, 32'h0, 32'h0));
    send_item(make_req(htw_pkg::MODE_CREATE, 16'h0000, 32'd1, 32'd0));
    send_item(make_req(htw_pkg::MODE_CREATE, 16'hFFFF, 32'd2, 32'd3));
    send_item(make_req(htw_pkg::MODE_CREATE, 16'hFFFF, 32'd5, 32'd0));
    send_item(make_req(htw_pkg::MODE_CREATE, 16'h1234, 32'd0, 32'd7));
    send_item(make_req(htw_pkg::MODE_CREATE, 16'hA5A5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_req(htw_pkg::MODE_KILL, 16'hA5A5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_req(htw_pkg::MODE_KILL, 16'hA5A5, 32'h0, 32'h0));
    send_item(make_req(htw_pkg::MODE_CREATE, 16'hA5A5, 32'd4, 32'd0));
    send_item(make_req(htw_pkg::MODE_KILL, 16'h5A5A, 32'h0, 32'h0));
    send_ticks(4);
    send_item(make_req(htw_pkg::MODE_KILL, 16'hA5A5, 32'h0, 32'h0));
    send_ticks(3);
    send_item(make_req(htw_pkg::MODE_KILL_ALL, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_ticks(5);
  endtask

  // fill the pool, then one expiry walk returns the whole slot list
  task automatic test_pool_full;
    for (int i = 0; i < NT + 1; i++)
      send_item(make_req(htw_pkg::MODE_CREATE, 16'(16'h0100 + i), 32'd2, 32'd0));
    send_item(make_req(htw_pkg::MODE_KILL, 16'h0105, 32'h0, 32'h0));
    send_item(make_req(htw_pkg::MODE_CREATE, 16'h0200, 32'd2, 32'd0));
    send_ticks(3);
  endtask

  // run past the wheel 0 wrap so that wheel 1 cascades
  task automatic test_rollover;
    send_item(make_req(htw_pkg::MODE_CREATE, 16'h0300, 32'd240, 32'd0));
    send_item(make_req(htw_pkg::MODE_CREATE, 16'h0301, 32'd250, 32'd0));
    send_item(make_req(htw_pkg::MODE_CREATE, 16'h0302, 32'd258, 32'd0));
    send_item(make_req(htw_pkg::MODE_CREATE, 16'h0303, 32'd40, 32'd60));
    send_item(make_req(htw_pkg::MODE_CREATE, 16'h0304, 32'd262, 32'd0));
    send_item(make_req(htw_pkg::MODE_KILL, 16'h0304, 32'h0, 32'h0));
    send_ticks(260);
    send_item(make_req(htw_pkg::MODE_KILL, 16'h0303, 32'h0, 32'h0));
  endtask

  // mostly well-formed traffic over a small id set, some noise
  task automatic test_random(input int cnt);
    int pick;
    logic [15:0] id;
    logic [31:0] due;
    logic [31:0] per;
    repeat (cnt) begin
      pick = $urandom_range(99);
      id = 16'($urandom_range(0, 23));
      due = 32'($urandom_range(1, 40));
      per = ($urandom_range(2) == 0) ? 32'($urandom_range(1, 50)) : 32'd0;
      if (pick < 48) send_ticks($urandom_range(1, 3));
      else if (pick < 76) begin
        if ($urandom_range(19) == 0) due = 32'd0;
        send_item(make_req(htw_pkg::MODE_CREATE, id, due, per));
      end else if (pick < 92) begin
        send_item(make_req(htw_pkg::MODE_KILL, id, $urandom, $urandom));
      end else if (pick < 94) begin
        send_item(make_req(htw_pkg::MODE_KILL_ALL, 16'($urandom), $urandom, $urandom));
      end else if (pick < 97) begin
        send_item(make_req(htw_pkg::mode_t'($urandom_range(3)), 16'($urandom), $urandom,
                           $urandom));
      end else begin
        send_item(make_req(htw_pkg::MODE_CREATE, 16'($urandom), $urandom, $urandom));
      end
    end
  endtask

  initial begin
    now_ticks = '0;
    for (int s = 0; s < NW * NSL; s++) begin
      slot_first[s] = NO_NODE;
      slot_last[s] = NO_NODE;
    end
    for (int i = 0; i < NT; i++) begin
      node_next[i] = '0;
      node_due[i] = '0;
      node_rep[i] = '0;
      node_id[i] = '0;
      node_busy[i] = 1'b0;
      node_live[i] = 1'b0;
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 13;
    stall_pct = 71;
    test_basic_ops();
    test_pool_full();
    send_idle_pct = 71;
    stall_pct = 13;
    test_rollover();
    send_idle_pct = 0;
    stall_pct = 0;
    test_random(12);

    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("sent %0d requests, checked %0d results (%0d expiries), %0d mismatches",
             items_sent, rsp_seen, expiries_seen, mismatches);
    $display("covered create, kill, tick, kill-all, pool full, duplicates and wheel cascade");
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("** hierarchical_timer_wheel: PASSED **");
    end else begin
      $display("** hierarchical_timer_wheel: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("timeout, %0d results still outstanding", expected_rsp.size());
    $display("** hierarchical_timer_wheel: FAILED **");
    $finish;
  end

endmodule

/* files.f */
rtl/htw_pkg.sv
rtl/htw_datapath.sv
rtl/htw_ctrl.sv
rtl/hierarchical_timer_wheel.sv
tb/sv/tb_hierarchical_timer_wheel.sv
